### hdl/pqe_pkg.sv
// Package: widths, constants, arctangent table and register clamps for the polar quantizer.
`timescale 1ns / 1ps
package pqe_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NS   = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int GUARD = 8;
    localparam int XW    = 27;
    localparam int LAT   = 2 * NS + 5;
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    localparam logic [1:0] REG_PH_PREC  = 2'd0;
    localparam logic [1:0] REG_AMP_PREC = 2'd1;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          z;
        logic                 zero;
    } t_pqe_item;

    function automatic logic [31:0] f_atan(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
            16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;
            20: v = 32'h0000028C;  21: v = 32'h00000146;
            22: v = 32'h000000A3;  23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] f_clamp_pb(input logic [4:0] pb);
        logic [4:0] v;
        if (pb == 5'd0) v = 5'd1;
        else if (pb > 5'd16) v = 5'd16;
        else v = pb;
        return v;
    endfunction

    function automatic logic [3:0] f_clamp_ab(input logic [3:0] ab);
        return (ab > 4'd14) ? 4'd14 : ab;
    endfunction

endpackage

### hdl/pqe_if.sv
// Interfaces: sample input, result output and register write channels.
`timescale 1ns / 1ps
interface pqe_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] real_in;
    logic signed [15:0] imag_in;
    modport source (output valid, real_in, imag_in, input ready);
    modport sink   (input valid, real_in, imag_in, output ready);
endinterface

interface pqe_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] quant_real;
    logic signed [16:0] quant_imag;
    logic [14:0]        ph_err;
    logic [13:0]        amp_err;
    modport source (output valid, quant_real, quant_imag, ph_err, amp_err,
                    input ready);
    modport sink   (input valid, quant_real, quant_imag, ph_err, amp_err,
                    output ready);
endinterface

interface pqe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [4:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/polar_quantizer_with_error_unit.sv
// Top level: polar quantizer with error report, front, queue, back and registers.
//
//  channel  | dir | handshake          | payload
//  i_in     | in  | valid/ready        | real_in, imag_in
//  o_out    | out | valid/ready        | quant_real, quant_imag, ph_err, amp_err
//  i_cfg    | in  | valid/ready (=1)   | index, data
//
// One item per cycle sustained while o_out is ready; stages: front register, queue,
// 16 vectoring stages, four gain and quantize stages, 16 rotation stages, output.
// Synchronous active-low reset clears valids and loads both precision registers to 12.
// A stalled output freezes the back pipeline; the queue absorbs the front meanwhile.
`timescale 1ns / 1ps
module polar_quantizer_with_error_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pqe_in_if.sink    i_in,
    pqe_out_if.source o_out,
    pqe_cfg_if.sink   i_cfg
);
    import pqe_pkg::*;

    logic [4:0] r_pb;
    logic [3:0] r_ab;
    logic       w_f_valid;
    t_pqe_item  w_f_item;
    logic       w_q_ready;
    logic       w_q_valid;
    t_pqe_item  w_q_item;
    logic       w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb <= 5'd12;
            r_ab <= 4'd12;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_PH_PREC) r_pb <= i_cfg.data;
            if (i_cfg.index == REG_AMP_PREC) r_ab <= i_cfg.data[3:0];
        end
    end

    pqe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_valid   (w_f_valid),
        .o_item    (w_f_item)
    );

    pqe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_item  (w_f_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    pqe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .i_pb    (r_pb),
        .i_ab    (r_ab),
        .o_out   (o_out)
    );
endmodule

### hdl/pqe_front.sv
// Front: accept samples, detect zero, fold the left half plane, register for the queue.
`timescale 1ns / 1ps
module pqe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pqe_in_if.sink            i_in,
    input  logic              i_q_ready,
    output logic              o_valid,
    output pqe_pkg::t_pqe_item o_item
);
    import pqe_pkg::*;

    logic      r_vld;
    t_pqe_item r_item;
    t_pqe_item n_item;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_y;

    assign i_in.ready = !r_vld || i_q_ready;
    assign o_valid    = r_vld;
    assign o_item     = r_item;

    always_comb begin
        w_x = XW'(i_in.real_in) <<< GUARD;
        w_y = XW'(i_in.imag_in) <<< GUARD;
        n_item.zero = (i_in.real_in == 16'sd0) && (i_in.imag_in == 16'sd0);
        if (i_in.real_in < 0) begin
            n_item.x = -w_x;
            n_item.y = -w_y;
            n_item.z = 32'h80000000;
        end else begin
            n_item.x = w_x;
            n_item.y = w_y;
            n_item.z = 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_item <= n_item;
        end
    end
endmodule

### hdl/pqe_queue.sv
// Queue: four-entry FIFO between front and back.
`timescale 1ns / 1ps
module pqe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pqe_pkg::t_pqe_item i_item,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output pqe_pkg::t_pqe_item o_item
);
    import pqe_pkg::*;

    t_pqe_item  r_mem [0:3];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, w_push} - {2'b0, w_pop};
        end
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

### hdl/pqe_back.sv
// Back: vectoring CORDIC, gain and quantization, rotating CORDIC, output register.
`timescale 1ns / 1ps
module pqe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pqe_pkg::t_pqe_item i_item,
    output logic              o_pop,
    input  logic [4:0]        i_pb,
    input  logic [3:0]        i_ab,
    pqe_out_if.source         o_out
);
    import pqe_pkg::*;

    logic [LAT-1:0] r_vld;
    logic           w_adv;

    logic signed [XW-1:0] r_vx [0:NS-1];
    logic signed [XW-1:0] r_vy [0:NS-1];
    logic [31:0]          r_vz [0:NS-1];
    logic                 r_vzero [0:NS-1];

    logic [55:0] r_prod;
    logic [31:0] r_m1_z;
    logic        r_m1_zero;

    logic [16:0] r_qmag;
    logic [16:0] r_qang;
    logic [16:0] r_perr;
    logic [17:0] r_merr;

    logic [46:0] r_prod2;
    logic [16:0] r_m3_qang;
    logic [16:0] r_m3_perr;
    logic [17:0] r_m3_merr;

    logic signed [XW-1:0] r_rx [0:NS];
    logic signed [XW-1:0] r_ry [0:NS];
    logic signed [31:0]   r_rz [0:NS];
    logic [16:0]          r_pe [0:NS];
    logic [17:0]          r_me [0:NS];

    logic signed [16:0] r_ore;
    logic signed [16:0] r_oim;
    logic [14:0]        r_ope;
    logic [13:0]        r_ome;

    assign w_adv = !r_vld[LAT-1] || o_out.ready;
    assign o_pop = w_adv && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_vec
            logic signed [XW-1:0] w_x;
            logic signed [XW-1:0] w_y;
            logic [31:0]          w_z;
            logic                 w_zero;
            if (k == 0) begin : g_first
                assign w_x = i_item.x;
                assign w_y = i_item.y;
                assign w_z = i_item.z;
                assign w_zero = i_item.zero;
            end else begin : g_next
                assign w_x = r_vx[k-1];
                assign w_y = r_vy[k-1];
                assign w_z = r_vz[k-1];
                assign w_zero = r_vzero[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_vzero[k] <= w_zero;
                    if (w_y >= 0) begin
                        r_vx[k] <= w_x + (w_y >>> k);
                        r_vy[k] <= w_y - (w_x >>> k);
                        r_vz[k] <= w_z + f_atan(k);
                    end else begin
                        r_vx[k] <= w_x - (w_y >>> k);
                        r_vy[k] <= w_y + (w_x >>> k);
                        r_vz[k] <= w_z - f_atan(k);
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod    <= 56'(r_vx[NS-1][25:0]) * 56'(KINV_Q30);
            r_m1_z    <= r_vz[NS-1];
            r_m1_zero <= r_vzero[NS-1];
        end
    end

    logic [55:0] w_msum;
    logic [31:0] w_asum;
    logic [17:0] w_mag;
    logic [16:0] w_ang;
    logic [3:0]  w_s;
    logic [4:0]  w_t;
    logic [17:0] w_mhalf;
    logic [16:0] w_ahalf;
    logic [17:0] w_qm;
    logic [16:0] w_qa;

    always_comb begin
        w_msum  = r_prod + (56'd1 << 37);
        w_asum  = r_m1_z + 32'h8000;
        w_mag   = r_m1_zero ? 18'd0 : w_msum[55:38];
        w_ang   = r_m1_zero ? 17'd0 : {1'b0, w_asum[31:16]};
        w_s     = 4'd14 - f_clamp_ab(i_ab);
        w_t     = 5'd16 - f_clamp_pb(i_pb);
        w_mhalf = (w_s != 4'd0) ? (18'd1 << (w_s - 4'd1)) : 18'd0;
        w_ahalf = (w_t != 5'd0) ? (17'd1 << (w_t - 5'd1)) : 17'd0;
        w_qm    = ((w_mag + w_mhalf) >> w_s) << w_s;
        w_qa    = ((w_ang + w_ahalf) >> w_t) << w_t;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qmag <= w_qm[16:0];
            r_qang <= w_qa;
            r_perr <= (w_ang > w_qa) ? (w_ang - w_qa) : (w_qa - w_ang);
            r_merr <= (w_mag > w_qm) ? (w_mag - w_qm) : (w_qm - w_mag);
            r_prod2   <= 47'(r_qmag) * 47'(KINV_Q30);
            r_m3_qang <= r_qang;
            r_m3_perr <= r_perr;
            r_m3_merr <= r_merr;
        end
    end

    logic [46:0]          w_xsum;
    logic signed [XW-1:0] w_x0;
    logic [31:0]          w_a;
    logic [31:0]          w_aq;

    always_comb begin
        w_xsum = r_prod2 + (47'd1 << 21);
        w_x0   = XW'(w_xsum[46:22]);
        w_a    = {r_m3_qang[15:0], 16'h0};
        w_aq   = w_a + 32'h40000000;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_aq[31]) begin
                r_rx[0] <= -w_x0;
                r_rz[0] <= w_a + 32'h80000000;
            end else begin
                r_rx[0] <= w_x0;
                r_rz[0] <= w_a;
            end
            r_ry[0] <= '0;
            r_pe[0] <= r_m3_perr;
            r_me[0] <= r_m3_merr;
        end
    end

    generate
        for (k = 0; k < NS; k++) begin : g_rot
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_pe[k+1] <= r_pe[k];
                    r_me[k+1] <= r_me[k];
                    if (r_rz[k] >= 0) begin
                        r_rx[k+1] <= r_rx[k] - (r_ry[k] >>> k);
                        r_ry[k+1] <= r_ry[k] + (r_rx[k] >>> k);
                        r_rz[k+1] <= r_rz[k] - $signed(f_atan(k));
                    end else begin
                        r_rx[k+1] <= r_rx[k] + (r_ry[k] >>> k);
                        r_ry[k+1] <= r_ry[k] - (r_rx[k] >>> k);
                        r_rz[k+1] <= r_rz[k] + $signed(f_atan(k));
                    end
                end
            end
        end
    endgenerate

    logic signed [XW-1:0] w_xr;
    logic signed [XW-1:0] w_yr;

    always_comb begin
        w_xr = (r_rx[NS] + XW'(128)) >>> GUARD;
        w_yr = (r_ry[NS] + XW'(128)) >>> GUARD;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ore <= w_xr[16:0];
            r_oim <= w_yr[16:0];
            r_ope <= r_pe[NS][14:0];
            r_ome <= r_me[NS][13:0];
        end
    end

    assign o_out.valid      = r_vld[LAT-1];
    assign o_out.quant_real = r_ore;
    assign o_out.quant_imag = r_oim;
    assign o_out.ph_err     = r_ope;
    assign o_out.amp_err    = r_ome;
endmodule

### tb/polar_quantizer_with_error_unit_test.sv
// Testbench: random and directed samples against a bit-exact polar quantizer predictor.
`timescale 1ns / 1ps
module polar_quantizer_with_error_unit_test;
    import pqe_pkg::*;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } t_sample;

    typedef struct packed {
        logic signed [16:0] qre;
        logic signed [16:0] qim;
        logic [14:0]        perr;
        logic [13:0]        merr;
    } t_quant;

    localparam longint KINV = 64'sd652032874;
    localparam int     CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    pqe_in_if  samp_if ();
    pqe_out_if quant_if ();
    pqe_cfg_if reg_if ();

    polar_quantizer_with_error_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (samp_if),
        .o_out   (quant_if),
        .i_cfg   (reg_if)
    );

    t_sample    samples_pending[$];
    t_quant     quant_expected[$];
    logic [4:0] cur_pb;
    logic [3:0] cur_ab;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_phase;
    int         stall_mode = 0;
    bit         drive_on;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic t_quant quantize_sample(t_sample smp, logic [4:0] pb_reg,
                                               logic [3:0] ab_reg);
        t_quant     r;
        longint     x, y, dx, dy, z2, qx, qy;
        logic [31:0] z, a;
        longint     mag, ang, qmag, qang, half, perr, merr;
        int         pb, ab, s, t;
        pb = (pb_reg < 1) ? 1 : ((pb_reg > 16) ? 16 : int'(pb_reg));
        ab = (ab_reg > 14) ? 14 : int'(ab_reg);
        if (smp.re == 0 && smp.im == 0) begin
            mag = 0;
            ang = 0;
        end else begin
            x = longint'(smp.re) * 256;
            y = longint'(smp.im) * 256;
            z = 32'h0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h80000000;
            end
            for (int i = 0; i < NS; i++) begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; z += f_atan(i);
                end else begin
                    x -= dx; y += dy; z -= f_atan(i);
                end
            end
            mag = (x * KINV + (64'sd1 <<< 37)) >>> 38;
            mag = mag & 64'hFFFFFFFF;
            z = z + 32'h8000;
            ang = longint'(z[31:16]);
        end
        s = 14 - ab;
        half = s ? (64'sd1 <<< (s - 1)) : 0;
        qmag = ((mag + half) >>> s) <<< s;
        t = 16 - pb;
        half = t ? (64'sd1 <<< (t - 1)) : 0;
        qang = ((ang + half) >>> t) <<< t;
        perr = (ang > qang) ? ang - qang : qang - ang;
        merr = (mag > qmag) ? mag - qmag : qmag - mag;

        a = {qang[15:0], 16'h0};
        qx = (qmag * KINV + (64'sd1 <<< 21)) >>> 22;
        qy = 0;
        if (((a + 32'h40000000) & 32'h80000000) != 0) begin
            qx = -qx;
            a = a + 32'h80000000;
        end
        z2 = a[31] ? longint'(a) - 64'sd4294967296 : longint'(a);
        for (int i = 0; i < NS; i++) begin
            dx = fshift(qy, i);
            dy = fshift(qx, i);
            if (z2 >= 0) begin
                qx -= dx; qy += dy; z2 -= longint'(f_atan(i));
            end else begin
                qx += dx; qy -= dy; z2 += longint'(f_atan(i));
            end
        end
        qx = fshift(qx + 128, GUARD);
        qy = fshift(qy + 128, GUARD);
        r.qre  = qx[16:0];
        r.qim  = qy[16:0];
        r.perr = perr[14:0];
        r.merr = merr[13:0];
        return r;
    endfunction

    // sender: bursts and gaps
    always @(posedge i_clk) begin
        if (!i_rst_n || !drive_on) begin
            samp_if.valid   <= 1'b0;
            samp_if.real_in <= '0;
            samp_if.imag_in <= '0;
        end else if (!samp_if.valid || samp_if.ready) begin
            if (samp_if.valid) begin
                quant_expected.insert(quant_expected.size(),
                                      quantize_sample({samp_if.real_in, samp_if.imag_in},
                                                      cur_pb, cur_ab));
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                samp_if.valid <= 1'b0;
            end else if (samples_pending.size() > 0) begin
                t_sample nx;
                nx = samples_pending.pop_front();
                samp_if.valid   <= 1'b1;
                samp_if.real_in <= nx.re;
                samp_if.imag_in <= nx.im;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
            end else begin
                samp_if.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern and compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quant_if.ready <= 1'b0;
            stall_phase    <= 0;
        end else begin
            if (quant_if.valid && quant_if.ready) begin
                if (quant_expected.size() == 0) begin
                    $error("unexpected result item");
                    mismatches++;
                end else begin
                    t_quant e;
                    e = quant_expected.pop_front();
                    if (quant_if.quant_real !== e.qre) begin
                        $error("quant_real exp %0d got %0d", e.qre, quant_if.quant_real);
                        mismatches++;
                    end
                    if (quant_if.quant_imag !== e.qim) begin
                        $error("quant_imag exp %0d got %0d", e.qim, quant_if.quant_imag);
                        mismatches++;
                    end
                    if (quant_if.ph_err !== e.perr) begin
                        $error("ph_err exp %0d got %0d", e.perr, quant_if.ph_err);
                        mismatches++;
                    end
                    if (quant_if.amp_err !== e.merr) begin
                        $error("amp_err exp %0d got %0d", e.merr, quant_if.amp_err);
                        mismatches++;
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            if (stall_phase % 200 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: quant_if.ready <= 1'b1;
                1: quant_if.ready <= (stall_phase % 5) != 0;
                2: quant_if.ready <= ($urandom_range(0, 3) != 0);
                default: quant_if.ready <= ((stall_phase / 7) % 3) != 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL polar_quantizer_with_error_unit");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(posedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        do @(posedge i_clk); while (!reg_if.ready);
        reg_if.valid <= 1'b0;
        if (idx == REG_PH_PREC) cur_pb = val;
        else if (idx == REG_AMP_PREC) cur_ab = val[3:0];
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (samples_pending.size() > 0 || samp_if.valid || quant_expected.size() > 0)
            @(negedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic add_sample(logic [15:0] re, logic [15:0] im);
        t_sample smp;
        smp.re = re;
        smp.im = im;
        samples_pending.insert(samples_pending.size(), smp);
    endtask

    task automatic add_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k == 0) add_sample(16'($urandom_range(0, 15)) - 16'd8,
                                   16'($urandom_range(0, 15)) - 16'd8);
            else if (k == 1) add_sample(16'h8000 | 16'($urandom_range(0, 3)),
                                        16'($urandom()));
            else add_sample(16'($urandom()), 16'($urandom()));
        end
    endtask

    initial begin
        logic [4:0] pbs[6] = '{5'd12, 5'd0, 5'd1, 5'd16, 5'd31, 5'd7};
        logic [3:0] abs_[6] = '{4'd12, 4'd0, 4'd14, 4'd15, 4'd3, 4'd9};
        i_rst_n        = 1'b0;
        drive_on       = 1'b0;
        reg_if.valid   = 1'b0;
        reg_if.index   = '0;
        reg_if.data    = '0;
        cur_pb         = 5'd12;
        cur_ab         = 4'd12;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drive_on <= 1'b1;
        @(posedge i_clk);

        add_sample(16'h0000, 16'h0000);
        add_sample(16'h7FFF, 16'h0000);
        add_sample(16'h8000, 16'h0000);
        add_sample(16'h0000, 16'h7FFF);
        add_sample(16'h0000, 16'h8000);
        add_sample(16'h8000, 16'h8000);
        add_sample(16'h7FFF, 16'h7FFF);
        add_sample(16'h7FFF, 16'h8000);
        add_sample(16'h8000, 16'h7FFF);
        add_sample(16'h4000, 16'hFFFF);
        add_sample(16'h4000, 16'h0001);
        add_sample(16'hFFFF, 16'h0000);
        add_sample(16'h0001, 16'h0000);
        add_sample(16'hC000, 16'hFFFF);
        add_sample(16'hC000, 16'h0001);
        add_sample(16'h2D41, 16'h2D41);
        add_sample(16'hFFFF, 16'hFFFF);
        add_sample(16'h0001, 16'hFFFF);
        add_random(60);
        settle();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_PH_PREC, pbs[p]);
            write_reg(REG_AMP_PREC, {1'b0, abs_[p]});
            write_reg(2'd2, 5'($urandom()));
            write_reg(2'd3, 5'($urandom()));
            add_sample(16'h0000, 16'h0000);
            add_sample(16'hFFFF, 16'h0000);
            add_sample(16'h7FFF, 16'hFFFF);
            add_random(p == 0 ? 200 : 220);
            settle();
        end

        if (mismatches == 0) begin
            $display("PASS polar_quantizer_with_error_unit");
        end else begin
            $display("FAIL polar_quantizer_with_error_unit");
        end
        $finish;
    end
endmodule
